// ----- rtl/arpc_pkg.sv -----
// shared types, constants and sizes for the arp cache and responder
package arpc_pkg;

    // cache geometry
    localparam int CACHE_ENTRIES = 16;
    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(CACHE_ENTRIES);

    // command queue between front and back (power of two depth)
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    localparam int REG_IDX_W = 2;
    localparam int REG_DATA_W = 48;
    localparam logic [REG_IDX_W-1:0] REG_LOCAL_IP  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_LOCAL_MAC = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_IP_CFG    = 2'd2;

    // protocol constants
    localparam logic [15:0] ARP_MIN_LEN    = 16'd28;
    localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
    localparam logic [31:0] BCAST_IP       = 32'hFFFF_FFFF;
    localparam logic [47:0] BCAST_MAC      = 48'hFFFF_FFFF_FFFF;

    // result kinds and emitted opcodes
    localparam logic [1:0] RES_REPLY = 2'd0;
    localparam logic [1:0] RES_HIT   = 2'd1;
    localparam logic [1:0] RES_MISS  = 2'd2;
    localparam logic [1:0] TX_OP_NONE    = 2'd0;
    localparam logic [1:0] TX_OP_REQUEST = 2'd1;
    localparam logic [1:0] TX_OP_REPLY   = 2'd2;

    typedef struct packed {
        logic        mode;
        logic [15:0] frame_len;
        logic [15:0] rx_opcode;
        logic [47:0] rx_sender_mac;
        logic [31:0] rx_sender_ip;
        logic [31:0] rx_target_ip;
        logic [31:0] lookup_ip;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [47:0] eth_dest_mac;
        logic [1:0]  tx_opcode;
        logic [31:0] tx_sender_ip;
        logic [47:0] tx_target_mac;
        logic [31:0] tx_target_ip;
        logic [47:0] resolved_mac;
    } result_t;

    typedef struct packed {
        logic [31:0] local_ip;
        logic [47:0] local_mac;
        logic        ip_configured;
    } cfg_t;

    typedef enum logic [1:0] {
        CMD_STORE  = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_BCAST  = 2'd2
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t     op;
        logic        reply;
        logic [31:0] key_ip;
        logic [47:0] mac;
    } cmd_t;

endpackage

// ----- rtl/arpc_front.sv -----
// front end: configuration registers, item classification and command queue
module arpc_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  arpc_pkg::in_item_t                item,
    input  logic                              wr_en,
    input  logic [arpc_pkg::REG_IDX_W-1:0]    wr_index,
    input  logic [arpc_pkg::REG_DATA_W-1:0]   wr_data,
    output arpc_pkg::cfg_t                    cfg,
    output logic                              cmd_valid,
    output arpc_pkg::cmd_t                    cmd,
    input  logic                              cmd_pop
);

    arpc_pkg::cfg_t cfg_reg;

    arpc_pkg::cmd_t                   q_reg [arpc_pkg::QUEUE_DEPTH];
    logic [arpc_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [arpc_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [arpc_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [arpc_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [arpc_pkg::QCNT_W-1:0]      cnt_reg;
    logic [arpc_pkg::QCNT_W-1:0]      cnt_next;

    arpc_pkg::cmd_t cmd_in;
    logic           keep;
    logic           enq;
    logic           deq;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                arpc_pkg::REG_LOCAL_IP:  cfg_reg.local_ip      <= wr_data[31:0];
                arpc_pkg::REG_LOCAL_MAC: cfg_reg.local_mac     <= wr_data[47:0];
                arpc_pkg::REG_IP_CFG:    cfg_reg.ip_configured <= wr_data[0];
                default:                 ;
            endcase
        end
    end

    // classify the incoming transaction
    always_comb
    begin
        cmd_in.mac    = item.rx_sender_mac;
        cmd_in.key_ip = item.mode ? item.lookup_ip : item.rx_sender_ip;
        cmd_in.reply  = !item.mode && (item.rx_opcode == arpc_pkg::ARP_OP_REQUEST)
                        && cfg_reg.ip_configured
                        && (item.rx_target_ip == cfg_reg.local_ip);
        if (!item.mode)
        begin
            cmd_in.op = arpc_pkg::CMD_STORE;
        end
        else if (item.lookup_ip == arpc_pkg::BCAST_IP)
        begin
            cmd_in.op = arpc_pkg::CMD_BCAST;
        end
        else
        begin
            cmd_in.op = arpc_pkg::CMD_LOOKUP;
        end
    end

    // short packets are dropped here and never queued
    assign keep = item.mode || (item.frame_len >= arpc_pkg::ARP_MIN_LEN);
    assign full = (cnt_reg == arpc_pkg::QCNT_W'(arpc_pkg::QUEUE_DEPTH));
    assign enq  = push && !full && keep;
    assign deq  = cmd_pop && cmd_valid;

    // queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (enq)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (deq)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (enq && !deq)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (deq && !enq)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign cfg       = cfg_reg;

endmodule

// ----- rtl/arpc_back.sv -----
// back end: cache scan, cache update and result register
module arpc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  arpc_pkg::cfg_t      cfg,
    input  logic                cmd_valid,
    input  arpc_pkg::cmd_t      cmd,
    output logic                cmd_pop,
    output logic                empty,
    input  logic                pop,
    output arpc_pkg::result_t   result
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // cache storage
    logic [31:0] ip_mem  [arpc_pkg::CACHE_ENTRIES];
    logic [47:0] mac_mem [arpc_pkg::CACHE_ENTRIES];
    logic [arpc_pkg::CACHE_ENTRIES-1:0] valid_reg;
    logic [31:0] rd_ip_reg;
    logic [47:0] rd_mac_reg;

    // scan control
    logic [arpc_pkg::CNT_W-1:0] rd_cnt_reg;
    logic [arpc_pkg::CNT_W-1:0] rd_cnt_next;
    logic                       cmp_vld_reg;
    logic                       cmp_vld_next;
    logic [arpc_pkg::IDX_W-1:0] cmp_idx_reg;
    logic [arpc_pkg::IDX_W-1:0] cmp_idx_next;
    logic                       free_found_reg;
    logic                       free_found_next;
    logic [arpc_pkg::IDX_W-1:0] free_idx_reg;
    logic [arpc_pkg::IDX_W-1:0] free_idx_next;
    logic [arpc_pkg::IDX_W-1:0] wr_idx_reg;
    logic [arpc_pkg::IDX_W-1:0] wr_idx_next;
    logic [arpc_pkg::IDX_W-1:0] rd_idx;

    // current command and results
    arpc_pkg::cmd_t    cmd_reg;
    arpc_pkg::cmd_t    cmd_next;
    arpc_pkg::result_t res_reg;
    arpc_pkg::result_t res_next;
    arpc_pkg::result_t out_reg;
    arpc_pkg::result_t out_next;
    logic              out_vld_reg;
    logic              out_vld_next;

    logic cmp_match;
    logic cmp_free;
    logic scan_last;
    logic mem_we;
    logic out_load;

    assign rd_idx    = rd_cnt_reg[arpc_pkg::IDX_W-1:0];
    assign cmp_match = cmp_vld_reg && valid_reg[cmp_idx_reg]
                       && (rd_ip_reg == cmd_reg.key_ip);
    assign cmp_free  = cmp_vld_reg && !valid_reg[cmp_idx_reg];
    assign scan_last = cmp_vld_reg && (cmp_idx_reg == arpc_pkg::LAST_IDX);
    assign mem_we    = (state_reg == ST_UPDATE);
    assign out_load  = (state_reg == ST_EMIT) && (!out_vld_reg || pop);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        res_next        = res_reg;
        rd_cnt_next     = rd_cnt_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        wr_idx_next     = wr_idx_reg;
        cmd_pop         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop         = 1'b1;
                    cmd_next        = cmd;
                    rd_cnt_next     = '0;
                    free_found_next = 1'b0;
                    if (cmd.op == arpc_pkg::CMD_BCAST)
                    begin
                        res_next              = '0;
                        res_next.result_kind  = arpc_pkg::RES_HIT;
                        res_next.resolved_mac = arpc_pkg::BCAST_MAC;
                        state_next            = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // issue the next read while the previous entry is compared
                if (rd_cnt_reg != arpc_pkg::CNT_END)
                begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = rd_idx;
                    rd_cnt_next  = rd_cnt_reg + 1'b1;
                end
                // remember the first empty slot
                if (cmp_free && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = cmp_idx_reg;
                end
                if (cmp_match)
                begin
                    cmp_vld_next = 1'b0;
                    if (cmd_reg.op == arpc_pkg::CMD_STORE)
                    begin
                        wr_idx_next = cmp_idx_reg;
                        state_next  = ST_UPDATE;
                    end
                    else
                    begin
                        res_next              = '0;
                        res_next.result_kind  = arpc_pkg::RES_HIT;
                        res_next.resolved_mac = rd_mac_reg;
                        state_next            = ST_EMIT;
                    end
                end
                else if (scan_last)
                begin
                    cmp_vld_next = 1'b0;
                    if (cmd_reg.op == arpc_pkg::CMD_STORE)
                    begin
                        if (free_found_reg)
                        begin
                            wr_idx_next = free_idx_reg;
                        end
                        else if (cmp_free)
                        begin
                            wr_idx_next = cmp_idx_reg;
                        end
                        else
                        begin
                            wr_idx_next = '0;
                        end
                        state_next = ST_UPDATE;
                    end
                    else
                    begin
                        res_next               = '0;
                        res_next.result_kind   = arpc_pkg::RES_MISS;
                        res_next.eth_dest_mac  = arpc_pkg::BCAST_MAC;
                        res_next.tx_opcode     = arpc_pkg::TX_OP_REQUEST;
                        res_next.tx_sender_ip  = cfg.local_ip;
                        res_next.tx_target_mac = '0;
                        res_next.tx_target_ip  = cmd_reg.key_ip;
                        state_next             = ST_EMIT;
                    end
                end
            end

            ST_UPDATE:
            begin
                if (cmd_reg.reply)
                begin
                    res_next               = '0;
                    res_next.result_kind   = arpc_pkg::RES_REPLY;
                    res_next.eth_dest_mac  = cmd_reg.mac;
                    res_next.tx_opcode     = arpc_pkg::TX_OP_REPLY;
                    res_next.tx_sender_ip  = cfg.local_ip;
                    res_next.tx_target_mac = cmd_reg.mac;
                    res_next.tx_target_ip  = cmd_reg.key_ip;
                    state_next             = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_EMIT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_next     = out_reg;
        out_vld_next = out_vld_reg;
        if (pop && out_vld_reg)
        begin
            out_vld_next = 1'b0;
        end
        if (out_load)
        begin
            out_next     = res_reg;
            out_vld_next = 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rd_cnt_reg     <= '0;
            cmp_vld_reg    <= 1'b0;
            free_found_reg <= 1'b0;
            out_vld_reg    <= 1'b0;
            valid_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_cnt_reg     <= rd_cnt_next;
            cmp_vld_reg    <= cmp_vld_next;
            free_found_reg <= free_found_next;
            out_vld_reg    <= out_vld_next;
            if (mem_we)
            begin
                valid_reg[wr_idx_reg] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        res_reg       <= res_next;
        out_reg       <= out_next;
        cmp_idx_reg   <= cmp_idx_next;
        free_idx_reg  <= free_idx_next;
        wr_idx_reg    <= wr_idx_next;
    end

    // cache memory, one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ip_mem[wr_idx_reg]  <= cmd_reg.key_ip;
            mac_mem[wr_idx_reg] <= cmd_reg.mac;
        end
        if (state_reg == ST_SCAN)
        begin
            rd_ip_reg  <= ip_mem[rd_idx];
            rd_mac_reg <= mac_mem[rd_idx];
        end
    end

    assign empty  = !out_vld_reg;
    assign result = out_reg;

endmodule

// ----- rtl/arp_cache_responder_unit.sv -----
// top level of the arp cache and responder
//
// channel   direction  handshake             payload
// input     in         push / full           item   (arpc_pkg::in_item_t)
// result    out        empty / pop           result (arpc_pkg::result_t)
// config    in         wr_en                 wr_index, wr_data
//
// a lookup or stored packet waits for the scan of the cache memory, one entry per
// cycle; a matching entry ends the scan early, and a broadcast lookup skips the
// scan and goes straight to the emit step
// a short packet is dropped on acceptance
// reset empties the cache at once through the valid bits; no clearing pass
// a two-deep command queue keeps input open while the scan runs, and a full
// result register holds the back end in its emit step until pop
module arp_cache_responder_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  arpc_pkg::in_item_t                item,
    output logic                              empty,
    input  logic                              pop,
    output arpc_pkg::result_t                 result,
    input  logic                              wr_en,
    input  logic [arpc_pkg::REG_IDX_W-1:0]    wr_index,
    input  logic [arpc_pkg::REG_DATA_W-1:0]   wr_data
);

    arpc_pkg::cfg_t cfg;
    arpc_pkg::cmd_t cmd;
    logic           cmd_valid;
    logic           cmd_pop;

    // accept, classify and queue
    arpc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // scan, update and respond
    arpc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

// ----- bench/arp_cache_responder_unit_tb.sv -----
// testbench for the arp cache and responder: directed and random transactions against a predictor
`timescale 1ns / 100ps

module arp_cache_responder_unit_tb;

    // item modes and a register index the block does not decode
    localparam logic MODE_PACKET = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;
    localparam logic [arpc_pkg::REG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [15:0] RX_OP_REPLY = 16'd2;

    // run pacing
    localparam int POOL_SIZE = 24;
    localparam int SETTLE_CYCLES = 100;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT = 10;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    arpc_pkg::in_item_t item = '0;
    logic empty;
    logic pop = 1'b0;
    arpc_pkg::result_t result;
    logic wr_en = 1'b0;
    logic [arpc_pkg::REG_IDX_W-1:0] wr_index = '0;
    logic [arpc_pkg::REG_DATA_W-1:0] wr_data = '0;

    // predictor copy of the cache and the registers
    logic cache_valid [arpc_pkg::CACHE_ENTRIES];
    logic [31:0] cache_ip [arpc_pkg::CACHE_ENTRIES];
    logic [47:0] cache_mac [arpc_pkg::CACHE_ENTRIES];
    logic [31:0] cfg_local_ip = '0;
    logic cfg_ip_ok = 1'b0;

    arpc_pkg::result_t results_due [$];
    logic [31:0] ip_pool [POOL_SIZE];
    bit idle_on = 1'b1;
    int fail_count = 0;
    int quiet_cycles = 0;

    arp_cache_responder_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .empty    (empty),
        .pop      (pop),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always #2 clk = ~clk;

    // cycles with no transaction on either side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("arp_cache_responder_unit_tb failed");
        $finish;
    end

    function automatic logic [47:0] rand_mac();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    function automatic string show_result(input arpc_pkg::result_t r);
        return $sformatf("kind=%0d dst=%h op=%0d sip=%h tmac=%h tip=%h rmac=%h",
                         r.result_kind, r.eth_dest_mac, r.tx_opcode, r.tx_sender_ip,
                         r.tx_target_mac, r.tx_target_ip, r.resolved_mac);
    endfunction

    // lowest valid slot holding ip, -1 when absent
    function automatic int find_cached(input logic [31:0] ip);
        for (int i = 0; i < arpc_pkg::CACHE_ENTRIES; i++)
            if (cache_valid[i] && cache_ip[i] == ip)
                return i;
        return -1;
    endfunction

    // update a known ip, else take the first free slot, else slot 0
    function automatic void learn_pair(input logic [31:0] ip, input logic [47:0] mac);
        int slot;
        slot = find_cached(ip);
        if (slot < 0)
        begin
            slot = 0;
            for (int i = arpc_pkg::CACHE_ENTRIES - 1; i >= 0; i--)
                if (!cache_valid[i])
                    slot = i;
            cache_valid[slot] = 1'b1;
            cache_ip[slot] = ip;
        end
        cache_mac[slot] = mac;
    endfunction

    // expected outcome of one accepted transaction
    function automatic void predict_arp(input arpc_pkg::in_item_t it);
        arpc_pkg::result_t r;
        int slot;
        r = '0;
        if (it.mode == MODE_PACKET)
        begin
            if (it.frame_len < arpc_pkg::ARP_MIN_LEN)
                return;
            learn_pair(it.rx_sender_ip, it.rx_sender_mac);
            if (it.rx_opcode == arpc_pkg::ARP_OP_REQUEST && cfg_ip_ok
                && it.rx_target_ip == cfg_local_ip)
            begin
                r.result_kind = arpc_pkg::RES_REPLY;
                r.eth_dest_mac = it.rx_sender_mac;
                r.tx_opcode = arpc_pkg::TX_OP_REPLY;
                r.tx_sender_ip = cfg_local_ip;
                r.tx_target_mac = it.rx_sender_mac;
                r.tx_target_ip = it.rx_sender_ip;
                results_due.push_back(r);
            end
            return;
        end
        slot = find_cached(it.lookup_ip);
        if (it.lookup_ip == arpc_pkg::BCAST_IP)
        begin
            r.result_kind = arpc_pkg::RES_HIT;
            r.resolved_mac = arpc_pkg::BCAST_MAC;
        end
        else if (slot >= 0)
        begin
            r.result_kind = arpc_pkg::RES_HIT;
            r.resolved_mac = cache_mac[slot];
        end
        else
        begin
            r.result_kind = arpc_pkg::RES_MISS;
            r.eth_dest_mac = arpc_pkg::BCAST_MAC;
            r.tx_opcode = arpc_pkg::TX_OP_REQUEST;
            r.tx_sender_ip = cfg_local_ip;
            r.tx_target_ip = it.lookup_ip;
        end
        results_due.push_back(r);
    endfunction

    // item builders; fields the mode ignores carry random bits
    function automatic arpc_pkg::in_item_t arp_packet(input logic [15:0] len,
                                                      input logic [15:0] opc,
                                                      input logic [47:0] mac,
                                                      input logic [31:0] sip,
                                                      input logic [31:0] tip);
        arpc_pkg::in_item_t it;
        it.mode = MODE_PACKET;
        it.frame_len = len;
        it.rx_opcode = opc;
        it.rx_sender_mac = mac;
        it.rx_sender_ip = sip;
        it.rx_target_ip = tip;
        it.lookup_ip = $urandom;
        return it;
    endfunction

    function automatic arpc_pkg::in_item_t arp_lookup(input logic [31:0] ip);
        arpc_pkg::in_item_t it;
        it = arp_packet(16'($urandom), 16'($urandom), rand_mac(), $urandom, $urandom);
        it.mode = MODE_LOOKUP;
        it.lookup_ip = ip;
        return it;
    endfunction

    // mostly well-formed traffic over a small address pool, with some noise
    function automatic arpc_pkg::in_item_t random_transaction();
        arpc_pkg::in_item_t it;
        int pick;
        logic [15:0] len;
        logic [15:0] opc;
        logic [31:0] sip;
        logic [31:0] tip;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            len = 16'($urandom_range(0, 27));
        else if (pick < 15)
            len = 16'($urandom);
        else
            len = 16'($urandom_range(28, 64));
        pick = $urandom_range(0, 99);
        opc = (pick < 50) ? arpc_pkg::ARP_OP_REQUEST : (pick < 80) ? RX_OP_REPLY
                                                                   : 16'($urandom);
        sip = ($urandom_range(0, 99) < 80) ? ip_pool[$urandom_range(0, POOL_SIZE - 1)]
                                             : 32'($urandom);
        pick = $urandom_range(0, 99);
        tip = (pick < 50) ? cfg_local_ip
            : (pick < 80) ? ip_pool[$urandom_range(0, POOL_SIZE - 1)] : 32'($urandom);
        if ($urandom_range(0, 99) < 45)
            return arp_packet(len, opc, rand_mac(), sip, tip);
        pick = $urandom_range(0, 99);
        it = arp_lookup((pick < 70) ? ip_pool[$urandom_range(0, POOL_SIZE - 1)]
                      : (pick < 78) ? arpc_pkg::BCAST_IP : 32'($urandom));
        return it;
    endfunction

    // one input transaction; push stays high afterwards for a following item
    task automatic send_item(input arpc_pkg::in_item_t it);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_arp(it);
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
    endtask

    // idle the block fully, covering items that produce no result
    task automatic settle();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [arpc_pkg::REG_IDX_W-1:0] idx,
                             input logic [arpc_pkg::REG_DATA_W-1:0] val);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= val;
        @(posedge clk);
        wr_en <= 1'b0;
        @(posedge clk);
        case (idx)
            arpc_pkg::REG_LOCAL_IP: cfg_local_ip = val[31:0];
            arpc_pkg::REG_IP_CFG:   cfg_ip_ok = val[0];
            default:                ;
        endcase
    endtask

    // result side: check each popped transaction, stall in bursts
    initial
    begin
        arpc_pkg::result_t want;
        string diff;
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (results_due.size() == 0)
                    note_failure($sformatf("unexpected result %s", show_result(result)));
                else
                begin
                    want = results_due.pop_front();
                    diff = "";
                    if (result.result_kind !== want.result_kind)
                        diff = {diff, " result_kind"};
                    if (result.eth_dest_mac !== want.eth_dest_mac)
                        diff = {diff, " eth_dest_mac"};
                    if (result.tx_opcode !== want.tx_opcode)
                        diff = {diff, " tx_opcode"};
                    if (result.tx_sender_ip !== want.tx_sender_ip)
                        diff = {diff, " tx_sender_ip"};
                    if (result.tx_target_mac !== want.tx_target_mac)
                        diff = {diff, " tx_target_mac"};
                    if (result.tx_target_ip !== want.tx_target_ip)
                        diff = {diff, " tx_target_ip"};
                    if (result.resolved_mac !== want.resolved_mac)
                        diff = {diff, " resolved_mac"};
                    if (diff != "")
                        note_failure($sformatf("mismatch in%s\n  expected %s\n  actual   %s",
                                               diff, show_result(want), show_result(result)));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 13);
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // reset registers: unconfigured, local ip zero
    task automatic test_lookup_unconfigured();
        send_item(arp_lookup(32'h0A00_0001));
        send_item(arp_lookup(arpc_pkg::BCAST_IP));
        send_item(arp_packet(16'd27, arpc_pkg::ARP_OP_REQUEST, 48'h0, 32'h0A00_0001, 32'h0));
        send_item(arp_lookup(32'h0A00_0001));
        send_item(arp_packet(arpc_pkg::ARP_MIN_LEN, arpc_pkg::ARP_OP_REQUEST,
                             48'h0011_2233_4455, 32'h0A00_0001, 32'h0));
        send_item(arp_lookup(32'h0A00_0001));
        settle();
    endtask

    // every register, plus a write to an undecoded index that must be ignored
    task automatic test_register_writes();
        write_reg(arpc_pkg::REG_LOCAL_IP, 48'hA5A5_C0A8_0101);
        write_reg(arpc_pkg::REG_LOCAL_MAC, 48'h0200_5E10_2030);
        write_reg(arpc_pkg::REG_IP_CFG, 48'h1);
        write_reg(REG_UNUSED, arpc_pkg::BCAST_MAC);
        send_item(arp_packet(16'hFFFF, arpc_pkg::ARP_OP_REQUEST, arpc_pkg::BCAST_MAC,
                             32'hFFFF_FFFE, cfg_local_ip));
        send_item(arp_lookup(32'hFFFF_FFFE));
        settle();
    endtask

    // opcode, target and length cases around the reply decision
    task automatic test_replies();
        send_item(arp_packet(16'd40, RX_OP_REPLY, 48'h0, 32'h0, cfg_local_ip));
        send_item(arp_lookup(32'h0));
        send_item(arp_packet(16'd28, 16'hFFFF, rand_mac(), 32'h0A00_0002, cfg_local_ip));
        send_item(arp_packet(16'd28, 16'h0, rand_mac(), 32'h0A00_0003, cfg_local_ip));
        send_item(arp_packet(16'd28, arpc_pkg::ARP_OP_REQUEST, rand_mac(), 32'h0A00_0004,
                             cfg_local_ip + 32'd1));
        send_item(arp_packet(16'd0, arpc_pkg::ARP_OP_REQUEST, rand_mac(), 32'h0A00_0005,
                             cfg_local_ip));
        send_item(arp_packet(16'd29, arpc_pkg::ARP_OP_REQUEST, rand_mac(), 32'h7F00_0001,
                             cfg_local_ip));
        settle();
    endtask

    // entry update, broadcast sender cached, and requests while unconfigured
    task automatic test_cache_update();
        send_item(arp_packet(16'd28, RX_OP_REPLY, 48'hAABB_CCDD_EEFF, 32'h0A00_0001, 32'h0));
        send_item(arp_lookup(32'h0A00_0001));
        send_item(arp_packet(16'd28, arpc_pkg::ARP_OP_REQUEST, 48'h1234_5678_9ABC,
                             arpc_pkg::BCAST_IP, cfg_local_ip));
        send_item(arp_lookup(arpc_pkg::BCAST_IP));
        settle();
        write_reg(arpc_pkg::REG_IP_CFG, 48'h0);
        send_item(arp_packet(16'd28, arpc_pkg::ARP_OP_REQUEST, rand_mac(), 32'h0A00_0006,
                             cfg_local_ip));
        send_item(arp_lookup(32'h0BAD_BEEF));
        settle();
    endtask

    // random traffic under one register setting
    task automatic test_random_traffic(input int count, input logic [31:0] ip,
                                       input logic [47:0] mac, input logic ok,
                                       input bit quiet, input bit pause_midway);
        arpc_pkg::in_item_t it;
        int counted;
        int stretch_left;
        bit paused;
        settle();
        write_reg(arpc_pkg::REG_LOCAL_IP, {16'($urandom), ip});
        write_reg(arpc_pkg::REG_LOCAL_MAC, mac);
        write_reg(arpc_pkg::REG_IP_CFG, {47'($urandom), ok});
        counted = 0;
        stretch_left = 0;
        paused = 1'b0;
        idle_on = !quiet;
        while (counted < count)
        begin
            // alternate stretches with and without idling
            if (!quiet && stretch_left == 0)
            begin
                idle_on = ($urandom_range(0, 3) != 0);
                stretch_left = $urandom_range(10, 40);
            end
            if (pause_midway && !paused && counted >= count / 2)
            begin
                drain_results();
                @(posedge clk);
                paused = 1'b1;
            end
            it = random_transaction();
            send_item(it);
            if (!(it.mode == MODE_PACKET && it.frame_len < arpc_pkg::ARP_MIN_LEN))
                counted++;
            if (stretch_left > 0)
                stretch_left--;
        end
    endtask

    initial
    begin
        for (int i = 0; i < arpc_pkg::CACHE_ENTRIES; i++)
        begin
            cache_valid[i] = 1'b0;
            cache_ip[i] = '0;
            cache_mac[i] = '0;
        end
        foreach (ip_pool[i])
            ip_pool[i] = $urandom;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_lookup_unconfigured();
        test_register_writes();
        test_replies();
        test_cache_update();
        test_random_traffic(160, ip_pool[0], rand_mac(), 1'b1, 1'b0, 1'b0);
        test_random_traffic(160, arpc_pkg::BCAST_IP, arpc_pkg::BCAST_MAC, 1'b1, 1'b0, 1'b0);
        test_random_traffic(160, 32'h0, 48'h0, 1'b0, 1'b0, 1'b1);
        test_random_traffic(160, ip_pool[1], rand_mac(), 1'b1, 1'b1, 1'b0);
        settle();

        if (fail_count == 0)
            $display("arp_cache_responder_unit_tb passed");
        else
            $display("arp_cache_responder_unit_tb failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/arpc_pkg.sv
rtl/arpc_front.sv
rtl/arpc_back.sv
rtl/arp_cache_responder_unit.sv
bench/arp_cache_responder_unit_tb.sv
